### hdl/rcpf_pkg.sv
// Shared constants, types and kernel tables for the RGB 3x3 preset filter.
package rcpf_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned PIX_W       = NUM_CH * CH_W;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned COL_W       = 11;
  localparam int unsigned KSEL_W      = 4;
  localparam int unsigned FW_W        = 12;
  localparam int unsigned FH_W        = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned KERNEL_SIZE   = 3;
  localparam int unsigned KTAPS         = KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned NUM_KERNELS   = 16;

  // results one pixel can cause: window centre, row-end column, last-row pixel
  localparam int unsigned EMIT_W = 3;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned COEF_W = 5;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned MAG_W  = 13;
  localparam int unsigned RECIP_W  = 13;
  localparam int unsigned RECIP_SH = 16;
  // ceil(2^16 / 9): exact floor quotient for every magnitude below 2^15
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);
  localparam logic [CH_W-1:0] CH_MAX = '1;

  localparam logic [KSEL_W-1:0] KSEL_RST = '0;
  localparam logic [FW_W-1:0]   FW_RST   = FW_W'(640);
  localparam logic [FH_W-1:0]   FH_RST   = FH_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SELECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = CFG_IDX_W'(2);

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    DIV_1,
    DIV_8,
    DIV_16,
    DIV_9
  } div_e;

  // taps in raster order: top row (oldest line) first, left column first
  localparam int KERN [NUM_KERNELS][KTAPS] = '{
    '{ 0, 0, 0,  0, 1, 0,  0, 0, 0},
    '{ 0, 0, 0,  0, 0, 0,  0, 0, 0},
    '{-1, 0, 1, -2, 0, 2, -1, 0, 1},
    '{-1, 0, 1, -1, 0, 1, -1, 0, 1},
    '{-1,-2,-1,  0, 0, 0,  1, 2, 1},
    '{-1,-1,-1,  0, 0, 0,  1, 1, 1},
    '{ 0,-1, 0, -1, 4,-1,  0,-1, 0},
    '{-1,-1,-1, -1, 8,-1, -1,-1,-1},
    '{-1,-2,-1, -2,12,-2, -1,-2,-1},
    '{-1,-1, 0, -1, 0, 1,  0, 1, 1},
    '{ 0, 1, 0,  1, 4, 1,  0, 1, 0},
    '{ 1, 2, 1,  2, 8, 2,  1, 2, 1},
    '{ 1, 1, 1,  1, 1, 1,  1, 1, 1},
    '{ 0, 0, 0,  0, 1, 0,  0, 0, 0},
    '{ 1, 1, 1,  1, 0, 1,  1, 1, 1},
    '{ 1, 1, 1,  1, 0, 1,  1, 1, 1}
  };

  localparam div_e KDIV [NUM_KERNELS] = '{
    DIV_1, DIV_1, DIV_1, DIV_1, DIV_1, DIV_1, DIV_1, DIV_1,
    DIV_1, DIV_1, DIV_8, DIV_16, DIV_9, DIV_1, DIV_8, DIV_8
  };

endpackage

### hdl/rcpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcpf_ram #(
  parameter int unsigned Width = 2 * rcpf_pkg::PIX_W,
  parameter int unsigned Depth = rcpf_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rgb_conv3x3_preset_filter_unit.sv
// Top level of the RGB 3x3 preset convolution filter with line store and result queue.
// Each input beat yields up to 3 results, which wait in the result queue until taken.
// Throughput: one pixel per clock, limited by 8 credits held from input beat to last result.
// Pixels causing 2 or 3 results (row ends, last row) present them one at a time on the output.
// Reset: counters, window, pipeline and queue clear; registers go to 0 / 640 / 480.
// The line store is not cleared: words read before they are written never reach a result in a well-formed frame.
module rgb_conv3x3_preset_filter_unit #(
  parameter int unsigned MAX_WIDTH = rcpf_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [rcpf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rcpf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // pixel input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rcpf_pkg::CH_W-1:0]          red_in_i,
  input  logic [rcpf_pkg::CH_W-1:0]          green_in_i,
  input  logic [rcpf_pkg::CH_W-1:0]          blue_in_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rcpf_pkg::ROW_W-1:0]         out_row_o,
  output logic [rcpf_pkg::COL_W-1:0]         out_col_o,
  output logic [rcpf_pkg::CH_W-1:0]          red_out_o,
  output logic [rcpf_pkg::CH_W-1:0]          green_out_o,
  output logic [rcpf_pkg::CH_W-1:0]          blue_out_o,
  output logic                               last_of_run_o
);

  import rcpf_pkg::*;

  // column counter and line store address width
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW   = (WW > FW_W) ? WW : FW_W;
  localparam int unsigned HCMPW  = FH_W;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [CW-1:0]     col;
    logic [EMIT_W-1:0] emit;      // [0] window centre, [1] row-end column, [2] last row
    logic              interior;
    pix_t              pix1;      // window centre (pass-through, later filtered)
    pix_t              pix2;      // line above at this column
    pix_t              pix3;      // incoming pixel
  } meta_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [KSEL_W-1:0] kern_q;
  logic [FW_W-1:0]   fw_q;
  logic [FH_W-1:0]   fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q <= KSEL_RST;
      fw_q   <= FW_RST;
      fh_q   <= FH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KERNEL_SELECT: kern_q <= cfg_data_i[KSEL_W-1:0];
        CFG_FRAME_WIDTH:   fw_q   <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT:  fh_q   <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size: zero acts as one, oversize acts as the maximum.
  logic [CMPW-1:0]  fw_x;
  logic [CMPW-1:0]  wm1_x;
  logic [CW-1:0]    wm1;
  logic [ROW_W-1:0] hm1;

  always_comb begin
    fw_x = CMPW'(fw_q);
    if (fw_q == '0) begin
      wm1_x = '0;
    end else if (fw_x > CMPW'(MAX_WIDTH)) begin
      wm1_x = CMPW'(MAX_WIDTH - 1);
    end else begin
      wm1_x = fw_x - CMPW'(1);
    end
    wm1 = CW'(wm1_x);

    if (fh_q == '0) begin
      hm1 = '0;
    end else if (fh_q > HCMPW'(MAX_HEIGHT)) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(fh_q - HCMPW'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: position counters and credit count
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]      row_q;
  logic [CW-1:0]         col_q;
  logic [FIFO_CNT_W-1:0] credit_q;
  logic                  in_acc;
  logic                  row_end;
  logic                  frame_end;
  logic [EMIT_W-1:0]     acc_emit;
  logic                  acc_interior;

  // Every accepted pixel holds one credit until its last result beat has gone
  // (or it leaves the pipeline without results), so the queue never overflows.
  assign in_stall_o = (credit_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;

  assign row_end   = (col_q >= wm1);
  assign frame_end = (row_q >= hm1);

  always_comb begin
    acc_emit[0] = (row_q != '0) && (col_q != '0);
    acc_emit[1] = (row_q != '0) && row_end;
    acc_emit[2] = frame_end;
    // positions beyond the frame after a size change never count as interior
    acc_interior = (row_q >= ROW_W'(2)) && (col_q >= CW'(2)) &&
                   (col_q <= wm1) && (row_q <= hm1);
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read in flight, forwarding from the write-back
  // ---------------------------------------------------------------------------
  logic              p1_vld_q;
  pix_t              p1_cur_q;
  logic [ROW_W-1:0]  p1_row_q;
  logic [CW-1:0]     p1_col_q;
  logic [EMIT_W-1:0] p1_emit_q;
  logic              p1_int_q;
  logic              p1_fwd_q;
  logic [2*PIX_W-1:0] p1_fwd_data_q;

  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] line_word;
  logic [2*PIX_W-1:0] wb_word;
  pix_t               col_now [KERNEL_SIZE];

  // Line store word: upper half two lines up, lower half the line above.
  rcpf_ram #(
    .Width (2 * PIX_W),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (p1_vld_q),
    .waddr_i (p1_col_q),
    .wdata_i (wb_word),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    // the pixel just ahead wrote this column at the same edge as our read
    line_word  = p1_fwd_q ? p1_fwd_data_q : ram_rdata;
    col_now[0] = line_word[2*PIX_W-1:PIX_W];
    col_now[1] = line_word[PIX_W-1:0];
    col_now[2] = p1_cur_q;
    wb_word    = {col_now[1], p1_cur_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      credit_q <= '0;
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= in_acc;
      credit_q <= credit_q + FIFO_CNT_W'(in_acc) - FIFO_CNT_W'(fifo_pop)
                  - FIFO_CNT_W'(zero_exit);
      if (in_acc) begin
        if (row_end) begin
          col_q <= '0;
          row_q <= frame_end ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_cur_q      <= {red_in_i, green_in_i, blue_in_i};
      p1_row_q      <= row_q;
      p1_col_q      <= col_q;
      p1_emit_q     <= acc_emit;
      p1_int_q      <= acc_interior;
      p1_fwd_q      <= p1_vld_q && (p1_col_q == col_q);
      p1_fwd_data_q <= wb_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Window columns and stage 2: assembled 3x3 window
  // ---------------------------------------------------------------------------
  pix_t  wc0_q [KERNEL_SIZE];
  pix_t  wc1_q [KERNEL_SIZE];
  logic  p2_vld_q;
  pix_t  p2_win_q [KERNEL_SIZE][KERNEL_SIZE];
  meta_t p2_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        wc0_q[i] <= '0;
        wc1_q[i] <= '0;
      end
    end else if (p1_vld_q) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        wc0_q[i] <= wc1_q[i];
        wc1_q[i] <= col_now[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      p2_win_q[i][0] <= wc0_q[i];
      p2_win_q[i][1] <= wc1_q[i];
      p2_win_q[i][2] <= col_now[i];
    end
    p2_meta_q.row      <= p1_row_q;
    p2_meta_q.col      <= p1_col_q;
    p2_meta_q.emit     <= p1_emit_q;
    p2_meta_q.interior <= p1_int_q;
    p2_meta_q.pix1     <= wc1_q[1];
    p2_meta_q.pix2     <= col_now[1];
    p2_meta_q.pix3     <= p1_cur_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-row partial sums for each channel
  // ---------------------------------------------------------------------------
  logic                    p3_vld_q;
  meta_t                   p3_meta_q;
  logic signed [SUM_W-1:0] p3_rs_q  [NUM_CH][KERNEL_SIZE];
  logic signed [SUM_W-1:0] rs_d     [NUM_CH][KERNEL_SIZE];
  logic signed [SUM_W-1:0] tap_px;
  logic signed [SUM_W-1:0] tap_coef;
  logic signed [COEF_W-1:0] coef;

  always_comb begin
    tap_px   = '0;
    tap_coef = '0;
    coef     = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        rs_d[ch][i] = '0;
        for (int j = 0; j < KERNEL_SIZE; j++) begin
          coef        = COEF_W'(KERN[kern_q][i*KERNEL_SIZE + j]);
          tap_coef    = SUM_W'(coef);
          tap_px      = signed'(SUM_W'(p2_win_q[i][j][ch*CH_W +: CH_W]));
          rs_d[ch][i] = rs_d[ch][i] + SUM_W'(tap_px * tap_coef);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p3_rs_q   <= rs_d;
    p3_meta_q <= p2_meta_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: full sum per channel
  // ---------------------------------------------------------------------------
  logic                    p4_vld_q;
  meta_t                   p4_meta_q;
  logic signed [SUM_W-1:0] p4_sum_q [NUM_CH];

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      p4_sum_q[ch] <= p3_rs_q[ch][0] + p3_rs_q[ch][1] + p3_rs_q[ch][2];
    end
    p4_meta_q <= p3_meta_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: divide, truncate toward zero, saturate
  // ---------------------------------------------------------------------------
  // Negative sums give a quotient of zero or less, which saturates to zero, so
  // only positive sums need dividing.
  logic                         p5_vld_q;
  meta_t                        p5_meta_q;
  pix_t                         p5_filt_q;
  pix_t                         filt_d;
  logic [MAG_W-1:0]             mag;
  logic [MAG_W+RECIP_W-1:0]     prod9;
  logic [MAG_W-1:0]             quot;

  always_comb begin
    filt_d = '0;
    mag    = '0;
    prod9  = '0;
    quot   = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      mag   = (p4_sum_q[ch] > 0) ? p4_sum_q[ch][MAG_W-1:0] : '0;
      prod9 = mag * RECIP9;
      case (KDIV[kern_q])
        DIV_1:   quot = mag;
        DIV_8:   quot = mag >> 3;
        DIV_16:  quot = mag >> 4;
        DIV_9:   quot = MAG_W'(prod9 >> RECIP_SH);
        default: quot = mag;
      endcase
      filt_d[ch*CH_W +: CH_W] = (quot > MAG_W'(CH_MAX)) ? CH_MAX : quot[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    p5_filt_q <= filt_d;
    p5_meta_q <= p4_meta_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: one entry per pixel that causes results, up to three beats each
  // ---------------------------------------------------------------------------
  meta_t                 fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q;
  logic [EMIT_W-1:0]     done_q;
  logic                  fifo_push;
  logic                  fifo_pop;
  logic                  zero_exit;
  logic                  out_beat;
  meta_t                 push_entry;
  meta_t                 head;
  logic [EMIT_W-1:0]     pend;
  logic [EMIT_W-1:0]     sel_oh;
  pix_t                  out_pix;
  logic [CW-1:0]         out_col_full;

  // drop pixels that cause no result; swap in the filtered centre when interior
  always_comb begin
    push_entry = p5_meta_q;
    if (p5_meta_q.interior) begin
      push_entry.pix1 = p5_filt_q;
    end
  end

  assign fifo_push = p5_vld_q && (p5_meta_q.emit != '0);
  assign zero_exit = p5_vld_q && (p5_meta_q.emit == '0);

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= push_entry;
    end
  end

  assign head = fifo_q[rd_ptr_q];
  assign pend = head.emit & ~done_q;

  always_comb begin
    // emit order: window centre, then row-end column, then last-row pixel
    if (pend[0]) begin
      sel_oh       = EMIT_W'(1);
      out_row_o    = head.row - ROW_W'(1);
      out_col_full = head.col - CW'(1);
      out_pix      = head.pix1;
    end else if (pend[1]) begin
      sel_oh       = EMIT_W'(2);
      out_row_o    = head.row - ROW_W'(1);
      out_col_full = head.col;
      out_pix      = head.pix2;
    end else begin
      sel_oh       = EMIT_W'(4);
      out_row_o    = head.row;
      out_col_full = head.col;
      out_pix      = head.pix3;
    end
  end

  assign out_valid_o   = (fifo_cnt_q != '0);
  assign out_col_o     = COL_W'(out_col_full);
  assign red_out_o     = out_pix[2*CH_W +: CH_W];
  assign green_out_o   = out_pix[CH_W +: CH_W];
  assign blue_out_o    = out_pix[0 +: CH_W];
  assign last_of_run_o = ((pend & ~sel_oh) == '0);

  assign out_beat = out_valid_o && !out_stall_i;
  assign fifo_pop = out_beat && last_of_run_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      done_q     <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (fifo_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(fifo_push) - FIFO_CNT_W'(fifo_pop);
      if (out_beat) begin
        // advance within the entry, clear the mask once its last beat goes
        done_q <= last_of_run_o ? '0 : (done_q | sel_oh);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (fifo_cnt_q < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue written while full");

  a_credit_covers_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q >= fifo_cnt_q)
    else $error("credit count below queue occupancy");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("credit count beyond queue depth");

  a_head_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend != '0))
    else $error("queue head shown with no result left");

endmodule
